// ----- rtl/cbts_pkg.sv -----
// shared types and constants for the can bit timing search block
`default_nettype none
package cbts_pkg;

  localparam int unsigned ClkW   = 27;
  localparam int unsigned RateW  = 20;
  localparam int unsigned DivW   = 4;
  localparam int unsigned WordW  = 15;
  localparam int unsigned ProdW  = 14;
  localparam int unsigned QdW    = 10;
  localparam int unsigned CntW   = 5;

  // divider runs one quotient bit per cycle
  localparam logic [CntW-1:0] DivLastCnt = CntW'(ClkW - 1);

  // search limits, counters hold d, q-1 and s-3
  localparam logic [3:0] DivMax     = 4'd15;
  localparam logic [4:0] PreM1Max   = 5'd31;
  localparam logic [3:0] RestMax    = 4'd14;
  localparam logic [2:0] SjwMax     = 3'd3;

  // configuration register index
  localparam logic RegClkHz = 1'b0;
  localparam logic [ClkW-1:0] ClkHzReset = 27'd48000000;

  typedef struct packed {
    logic start;
    logic div_step;
    logic srch_init;
    logic srch_step;
    logic load_out;
  } cbts_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic div_done;
    logic hit;
    logic srch_last;
  } cbts_sts_t;

endpackage
`default_nettype wire

// ----- rtl/cbts_dpath.sv -----
// datapath: clocks-per-bit divider, candidate search counters and result registers
`default_nettype none
module cbts_dpath import cbts_pkg::*; (
  input  wire logic             clk,
  input  wire logic [RateW-1:0] bit_rate,
  input  wire logic [ClkW-1:0]  clk_hz,
  input  wire cbts_cmd_t        cmd,
  output cbts_sts_t             sts,
  output logic                  out_found,
  output logic [DivW-1:0]       out_div,
  output logic [WordW-1:0]      out_word
);

  logic [RateW-1:0] dvs_r, dvs_nxt;
  logic [RateW-1:0] rem_r, rem_nxt;
  logic [ClkW-1:0]  quo_r, quo_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [RateW:0]   trial;
  logic             trial_ge;

  logic [3:0]       d_r, d_nxt;
  logic [4:0]       qm1_r, qm1_nxt;
  logic [3:0]       rest_r, rest_nxt;
  logic [QdW-1:0]   qd_r, qd_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic [QdW-1:0]   qd_inc;
  logic [QdW-1:0]   d_two;

  logic             res_found_r, res_found_nxt;
  logic [DivW-1:0]  res_div_r, res_div_nxt;
  logic [WordW-1:0] res_word_r, res_word_nxt;
  logic [WordW-1:0] word;
  logic [2:0]       seg1;
  logic [2:0]       seg2;
  logic [1:0]       sjw;
  logic             hit;

  logic             o_found_r, o_found_nxt;
  logic [DivW-1:0]  o_div_r, o_div_nxt;
  logic [WordW-1:0] o_word_r, o_word_nxt;

  // restoring division step, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[ClkW-1]};
    trial_ge = trial >= {1'b0, dvs_r};
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (cmd.start) begin
      dvs_nxt = bit_rate;
      rem_nxt = '0;
      quo_nxt = clk_hz;
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt = trial_ge ? RateW'(trial - {1'b0, dvs_r}) : trial[RateW-1:0];
      quo_nxt = {quo_r[ClkW-2:0], trial_ge};
      cnt_nxt = cnt_r + CntW'(1);
    end
  end

  // candidate product compare
  assign hit = (quo_r == ClkW'(prod_r));

  // timing word of the current candidate
  always_comb begin
    seg1 = rest_r[3:1];
    seg2 = 3'(rest_r - {1'b0, seg1});
    sjw  = (seg1 > SjwMax) ? 2'(SjwMax) : seg1[1:0];
    word = {seg2, 1'b0, seg1, sjw, 1'b0, qm1_r};
  end

  // search counters, product kept up to date by additions
  always_comb begin
    qd_inc        = qd_r + QdW'({1'b0, d_r} + 5'd1);
    d_two         = QdW'({1'b0, d_r} + 5'd2);
    d_nxt         = d_r;
    qm1_nxt       = qm1_r;
    rest_nxt      = rest_r;
    qd_nxt        = qd_r;
    prod_nxt      = prod_r;
    res_found_nxt = res_found_r;
    res_div_nxt   = res_div_r;
    res_word_nxt  = res_word_r;
    if (cmd.start) begin
      res_found_nxt = 1'b0;
      res_div_nxt   = '0;
      res_word_nxt  = '0;
    end
    if (cmd.srch_init) begin
      d_nxt    = '0;
      qm1_nxt  = '0;
      rest_nxt = '0;
      qd_nxt   = QdW'(1);
      prod_nxt = ProdW'(3);
    end else if (cmd.srch_step) begin
      if (hit) begin
        res_found_nxt = 1'b1;
        res_div_nxt   = d_r;
        res_word_nxt  = word;
      end else if (rest_r != RestMax) begin
        rest_nxt = rest_r + 4'd1;
        prod_nxt = prod_r + ProdW'(qd_r);
      end else if (qm1_r != PreM1Max) begin
        qm1_nxt  = qm1_r + 5'd1;
        rest_nxt = '0;
        qd_nxt   = qd_inc;
        prod_nxt = ProdW'({qd_inc, 1'b0}) + ProdW'(qd_inc);
      end else begin
        d_nxt    = d_r + 4'd1;
        qm1_nxt  = '0;
        rest_nxt = '0;
        qd_nxt   = d_two;
        prod_nxt = ProdW'({d_two, 1'b0}) + ProdW'(d_two);
      end
    end
  end

  // output payload register
  always_comb begin
    o_found_nxt = o_found_r;
    o_div_nxt   = o_div_r;
    o_word_nxt  = o_word_r;
    if (cmd.load_out) begin
      o_found_nxt = res_found_r;
      o_div_nxt   = res_div_r;
      o_word_nxt  = res_word_r;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    d_r         <= d_nxt;
    qm1_r       <= qm1_nxt;
    rest_r      <= rest_nxt;
    qd_r        <= qd_nxt;
    prod_r      <= prod_nxt;
    res_found_r <= res_found_nxt;
    res_div_r   <= res_div_nxt;
    res_word_r  <= res_word_nxt;
    o_found_r   <= o_found_nxt;
    o_div_r     <= o_div_nxt;
    o_word_r    <= o_word_nxt;
  end

  // status to the controller
  always_comb begin
    sts.rate_zero = (dvs_r == '0);
    sts.div_done  = (cnt_r == DivLastCnt);
    sts.hit       = hit;
    sts.srch_last = (d_r == DivMax) && (qm1_r == PreM1Max) && (rest_r == RestMax);
  end

  assign out_found = o_found_r;
  assign out_div   = o_div_r;
  assign out_word  = o_word_r;

endmodule
`default_nettype wire

// ----- rtl/cbts_ctrl.sv -----
// controller: request sequencing through divide, search and result hand-off
`default_nettype none
module cbts_ctrl import cbts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cbts_sts_t sts,
  output cbts_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.rate_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_done) begin
            cmd.srch_init = 1'b1;
            state_nxt     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.hit || sts.srch_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a result is only loaded into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending one");

  // an accepted request always starts the divider
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DIV))
    else $error("accepted request did not start division");

  // a candidate hit ends the search
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && sts.hit) |=> (state_r == ST_DONE))
    else $error("search went on past a hit");

endmodule
`default_nettype wire

// ----- rtl/can_bit_timing_search_core.sv -----
// top level: configuration registers, stream ports, controller and datapath
`default_nettype none
// CAN bit timing search. Each request carries a bit rate; the core divides the
// configured peripheral clock by it, one quotient bit per cycle, and then walks
// divider 0..15, prescaler 1..32 and segment total 3..17 one candidate per cycle
// until the first exact match of total*prescaler*(divider+1) with the clocks per
// bit. A zero rate returns a not-found result without division or search. One
// request is worked on at a time; a new one is taken while the previous result
// waits in the output register. Writing the clock register is allowed only while
// the core is idle.
module can_bit_timing_search_core import cbts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input request
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [19:0] bit_rate, [23:20] zero
  // result
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] clock_divider, [18:4] bit_timing_word, zero
  output logic             out_tuser,  // [0] found
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [ClkW-1:0] clk_hz_r, clk_hz_nxt;
  logic            cfg_wr;
  cbts_cmd_t       cmd;
  cbts_sts_t       sts;
  logic            res_found;
  logic [DivW-1:0] res_div;
  logic [WordW-1:0] res_word;

  // register write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    clk_hz_nxt = clk_hz_r;
    if (cfg_wr && (cfg_paddr[2] == RegClkHz)) begin
      clk_hz_nxt = cfg_pwdata[ClkW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= ClkHzReset;
    end else begin
      clk_hz_r <= clk_hz_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == RegClkHz) ? 32'(clk_hz_r) : 32'd0;

  // sequencing
  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result registers
  cbts_dpath u_dpath (
    .clk       (clk),
    .bit_rate  (in_tdata[RateW-1:0]),
    .clk_hz    (clk_hz_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_found (res_found),
    .out_div   (res_div),
    .out_word  (res_word)
  );

  assign out_tdata = {5'd0, res_word, res_div};
  assign out_tuser = res_found;

endmodule
`default_nettype wire

// ----- test/can_bit_timing_search_core_tb.sv -----
// testbench for the can bit timing search core: predictor, scoreboard and stimulus
module can_bit_timing_search_core_tb;
  import cbts_pkg::*;

  // run limits and register map
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned TailCycles = 200;
  localparam logic [2:0] ClkHzAddr = {RegClkHz, 2'b00};
  localparam logic [2:0] UnusedAddr = 3'd4;
  localparam logic [ClkW-1:0] ClkMaxHz = 27'd100_000_000;
  localparam int unsigned RateMax = 1_000_000;

  // search bounds of the timing search
  localparam int unsigned DivLimit = 15;
  localparam int unsigned PreLimit = 32;
  localparam int unsigned TotalMin = 3;
  localparam int unsigned TotalMax = 17;
  localparam int unsigned SjwCap = 3;

  typedef enum int unsigned {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic             found;
    logic [DivW-1:0]  divider;
    logic [WordW-1:0] word;
  } timing_t;

  // expected timings in request order, checked against each result
  class timing_checker;
    timing_t pending_timings[$];
    int unsigned errors = 0;

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    // first exact factorization of clocks per bit, divider outermost
    function timing_t search_timing(logic [RateW-1:0] rate, logic [ClkW-1:0] clk_hz);
      timing_t t;
      int unsigned clocks_per_bit, rest, seg1, seg2, sjw;
      t = '0;
      if (rate == 0) return t;
      clocks_per_bit = clk_hz / rate;
      for (int unsigned d = 0; d <= DivLimit; d++) begin
        for (int unsigned q = 1; q <= PreLimit; q++) begin
          for (int unsigned s = TotalMin; s <= TotalMax; s++) begin
            if (clocks_per_bit == s * q * (d + 1)) begin
              rest = s - TotalMin;
              seg1 = rest / 2;
              seg2 = rest - seg1;
              sjw = (seg1 > SjwCap) ? SjwCap : seg1;
              t.found = 1'b1;
              t.divider = DivW'(d);
              t.word = {seg2[2:0], seg1[3:0], sjw[1:0], 6'(q - 1)};
              return t;
            end
          end
        end
      end
      return t;
    endfunction

    function void note_rate(logic [RateW-1:0] rate, logic [ClkW-1:0] clk_hz);
      pending_timings.push_back(search_timing(rate, clk_hz));
    endfunction

    task check_timing(logic found, logic [DivW-1:0] divider, logic [WordW-1:0] word,
                      logic [4:0] pad);
      timing_t want;
      if (pending_timings.size() == 0) begin
        report($sformatf("result without request: found %0d divider %0d word 0x%04h",
                         found, divider, word));
        return;
      end
      want = pending_timings.pop_front();
      if (found !== want.found)
        report($sformatf("found got %0d want %0d", found, want.found));
      if (divider !== want.divider)
        report($sformatf("clock_divider got %0d want %0d", divider, want.divider));
      if (word !== want.word)
        report($sformatf("bit_timing_word got 0x%04h want 0x%04h", word, want.word));
      if (pad !== 5'b0)
        report($sformatf("tdata padding got 0x%02h want 0", pad));
    endtask

    function int unsigned pending();
      return pending_timings.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [ClkW-1:0] clk_hz_model = ClkHzReset;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;
  timing_checker book = new();

  can_bit_timing_search_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("can_bit_timing_search_core: mismatch");
      $finish;
    end
  end

  // monitor accepted requests and results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        book.note_rate(in_tdata[RateW-1:0], clk_hz_model);
      if (out_tvalid && out_tready)
        book.check_timing(out_tuser, out_tdata[3:0], out_tdata[18:4], out_tdata[23:19]);
    end
  end

  // result receiver with random stalls and a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one rate request, return at the edge it is accepted
  task automatic send_rate(input logic [RateW-1:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, rate};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ClkHzAddr) clk_hz_model = value[ClkW-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // clock register read back against the model copy
  task automatic read_clk_reg();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ClkHzAddr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {5'b0, clk_hz_model})
      book.report($sformatf("clock register read 0x%08h want 0x%08h",
                            cfg_prdata, {5'b0, clk_hz_model}));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly rates that factor into a timing, some raw noise
  function automatic logic [RateW-1:0] pick_rate();
    int unsigned d, q, s, rate;
    if ($urandom_range(99) < 20) return RateW'($urandom());
    d = ($urandom_range(9) == 0) ? $urandom_range(DivLimit) : $urandom_range(2);
    q = $urandom_range(PreLimit, 1);
    s = $urandom_range(TotalMax, TotalMin);
    rate = clk_hz_model / (s * q * (d + 1));
    if (rate == 0 || rate > RateMax) rate = $urandom_range(RateMax, 1);
    return RateW'(rate);
  endfunction

  // stimulus
  initial begin : stimulus
    idle_mode_e mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_clk_reg();

    // reset clock: zero rate, common rates, full-width rate, no-match rates
    send_rate('0);
    send_rate(20'd1_000_000);
    send_rate(20'd500_000);
    send_rate(20'd125_000);
    send_rate(20'hFFFFF);
    send_rate(20'd1);
    send_rate(20'd7);

    // first rate matches only at the largest divider, prescaler and total
    wait_drained();
    write_reg(ClkHzAddr, 32'd8704);
    read_clk_reg();
    send_rate(20'd1);
    send_rate(20'd2);
    send_rate(20'd3);

    // smallest candidate, and clocks per bit below it
    wait_drained();
    write_reg(ClkHzAddr, 32'd3);
    send_rate(20'd1);
    send_rate(20'd2);

    // zero clock register never matches
    wait_drained();
    write_reg(ClkHzAddr, 32'd0);
    read_clk_reg();
    send_rate(20'd1);
    send_rate(20'hFFFFF);

    // all data bits set, register keeps its low bits
    wait_drained();
    write_reg(ClkHzAddr, 32'hFFFF_FFFF);
    read_clk_reg();
    send_rate(20'hFFFFF);
    send_rate(20'd1_000_000);

    // top of the clock range
    wait_drained();
    write_reg(ClkHzAddr, {5'b0, ClkMaxHz});
    send_rate(20'd1_000_000);
    send_rate(20'd1);

    // write outside the register map is ignored
    wait_drained();
    write_reg(UnusedAddr, 32'h0123_4567);
    read_clk_reg();
    send_rate(20'd250_000);

    // bottom of the clock range
    wait_drained();
    write_reg(ClkHzAddr, 32'd1);
    read_clk_reg();
    send_rate(20'd1);
    send_rate('0);

    // receiver holds off while fast requests keep coming
    wait_drained();
    write_reg(ClkHzAddr, {5'b0, ClkHzReset});
    hold_req = 1'b1;
    repeat (8) send_rate(20'd1_000_000);

    // random phases with different idling
    for (int unsigned m = 0; m < 4; m++) begin
      mode = idle_mode_e'(m);
      case (mode)
        IdleNone: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IdleSender: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        IdleReceiver: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
      endcase
      for (int unsigned g = 0; g < 2; g++) begin
        wait_drained();
        if (mode == IdleBoth && g == 1)
          write_reg(ClkHzAddr, {5'b0, ClkMaxHz});
        else
          write_reg(ClkHzAddr, $urandom_range(ClkMaxHz, 1_000_000));
        read_clk_reg();
        repeat (10) send_rate(pick_rate());
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (book.errors == 0)
      $display("can_bit_timing_search_core: match");
    else
      $display("can_bit_timing_search_core: mismatch");
    $finish;
  end

endmodule
